/* rtl/core/mpq_pkg.sv */
// Shared types and constants for the max priority queue.
// Used by mpq_cell and max_priority_queue_top; no dependencies.
package mpq_pkg;

    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int COUNT_OUT_W = 5;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic signed [KEY_W-1:0] value;
    } cell_ctrl_t;

endpackage

/* rtl/core/max_priority_queue_top.sv */
// Max priority queue of signed 32-bit keys built as a chain of sorted cells.
// Depends on mpq_pkg and mpq_cell.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one request: s_operation selects
//   push s_value, pop the largest key, clear, or query only.
//   Result channel (m_valid/m_ready) returns one result per request: the
//   largest key after the operation (0 when empty), the key count (low five
//   bits), an empty flag and an error flag (push on full, pop on empty).
//   A failing push or pop leaves the stored keys untouched.
// Latency and throughput:
//   A request is handled in the cycle it is accepted; its result is valid on
//   the next cycle from the output register. One request per cycle while the
//   receiver takes results, set by the single compare-and-shift step that
//   every cell does in parallel.
// Reset:
//   aresetn (synchronous, active low) empties the queue and drops any pending
//   result. Key storage is not cleared; slots above the count are never read.
// Stall:
//   While a result waits and m_ready is low, s_ready is low and no request is
//   taken; the held result stays stable.
module max_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mpq_pkg::OP_W-1:0]         s_operation,
    input  logic signed [mpq_pkg::KEY_W-1:0] s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [mpq_pkg::KEY_W-1:0] m_top_value,
    output logic [mpq_pkg::COUNT_OUT_W-1:0]  m_count,
    output logic                             m_is_empty,
    output logic                             m_error
);
    import mpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                    accept;
    op_t                     op;
    cell_ctrl_t              ctrl;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    full;
    logic                    empty;
    logic                    err;
    logic signed [KEY_W-1:0] top_key;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    logic signed [KEY_W-1:0] key_w [CAPACITY];
    logic                    gt_w  [CAPACITY];

    logic                    m_valid_reg;
    logic signed [KEY_W-1:0] m_top_value_reg;
    logic [COUNT_OUT_W-1:0]  m_count_reg;
    logic                    m_is_empty_reg;
    logic                    m_error_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = op_t'(s_operation);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);

    // Decode the request into cell controls and the new count
    always_comb begin
        ctrl.push  = 1'b0;
        ctrl.pop   = 1'b0;
        ctrl.value = s_value;
        count_next = count_reg;
        err        = 1'b0;
        top_key    = key_w[0];
        unique case (op)
            OP_PUSH: begin
                if (full) begin
                    err = 1'b1;
                end else begin
                    ctrl.push  = accept;
                    count_next = count_reg + CW'(1);
                    top_key    = gt_w[0] ? s_value : key_w[0];
                end
            end
            OP_POP: begin
                if (empty) begin
                    err = 1'b1;
                end else begin
                    ctrl.pop   = accept;
                    count_next = count_reg - CW'(1);
                    top_key    = key_w[1];
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [KEY_W-1:0] prev_key;
        logic                    prev_gt;
        logic signed [KEY_W-1:0] next_key;

        if (i == 0) begin : g_first
            assign prev_key = '0;
            assign prev_gt  = 1'b0;
        end else begin : g_mid
            assign prev_key = key_w[i-1];
            assign prev_gt  = gt_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_key = key_w[i];
        end else begin : g_inner
            assign next_key = key_w[i+1];
        end

        mpq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .count    (count_reg),
            .prev_key (prev_key),
            .prev_gt  (prev_gt),
            .next_key (next_key),
            .key      (key_w[i]),
            .gt       (gt_w[i])
        );
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_top_value_reg <= (count_next == '0) ? '0 : top_key;
            m_count_reg     <= count_ext[COUNT_OUT_W-1:0];
            m_is_empty_reg  <= (count_next == '0);
            m_error_reg     <= err;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_top_value = m_top_value_reg;
    assign m_count     = m_count_reg;
    assign m_is_empty  = m_is_empty_reg;
    assign m_error     = m_error_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_sorted_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(2)) |-> (key_w[0] >= key_w[1]))
        else $error("head cells out of order");

    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_PUSH && full) |=> (m_error_reg && $stable(count_reg)))
        else $error("push on full queue not rejected");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_POP && empty) |=> (m_error_reg && m_is_empty_reg))
        else $error("pop on empty queue not rejected");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request produced no result");

endmodule

/* rtl/core/mpq_cell.sv */
// One slot of the sorted shift-register queue (largest key in cell 0).
// Depends on mpq_pkg for the key width and the control struct.
module mpq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                            aclk,
    input  mpq_pkg::cell_ctrl_t             ctrl,
    input  logic [CW-1:0]                   count,
    input  logic signed [mpq_pkg::KEY_W-1:0] prev_key,
    input  logic                            prev_gt,
    input  logic signed [mpq_pkg::KEY_W-1:0] next_key,
    output logic signed [mpq_pkg::KEY_W-1:0] key,
    output logic                            gt
);
    import mpq_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    occupied;

    assign occupied = (count > CW'(IDX));

    // Empty slots count as smaller than any key
    assign gt = !occupied || (ctrl.value > key_reg);

    // Push: insert at the first slot the new key beats, shift the rest down.
    // Pop: everything moves up one slot.
    always_comb begin
        key_next = key_reg;
        if (ctrl.push) begin
            if (gt) begin
                key_next = prev_gt ? prev_key : ctrl.value;
            end
        end else if (ctrl.pop) begin
            key_next = next_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

/* dv/tb.sv */
// Self-checking testbench for max_priority_queue_top: random and directed requests,
// results checked against a behavioral priority queue kept in the testbench.
// Depends on mpq_pkg and the max_priority_queue_top RTL.
`timescale 1ns / 100ps

module tb;
    import mpq_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_REQS  = 175;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

    typedef struct {
        op_t                     op;
        logic signed [KEY_W-1:0] value;
    } mpq_req_t;

    typedef struct {
        logic signed [KEY_W-1:0] top;
        logic [COUNT_OUT_W-1:0]  cnt;
        logic                    empty;
        logic                    err;
    } queue_status_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_operation = OP_QUERY;
    logic signed [KEY_W-1:0] s_value     = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic signed [KEY_W-1:0] m_top_value;
    logic [COUNT_OUT_W-1:0]  m_count;
    logic                    m_is_empty;
    logic                    m_error;

    mpq_req_t                pending_reqs[$];
    queue_status_t           expected_status[$];
    logic signed [KEY_W-1:0] stored_keys[$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int          fail_count   = 0;
    logic        hold_go      = 1'b0;
    logic        hold_active  = 1'b0;

    max_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_error     (m_error)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic int largest_index();
        int idx;
        idx = 0;
        for (int i = 1; i < stored_keys.size(); i++) begin
            if (stored_keys[i] > stored_keys[idx]) idx = i;
        end
        return idx;
    endfunction

    // Apply one request to the behavioral queue and queue up the status it yields
    task automatic predict_status(input op_t op, input logic signed [KEY_W-1:0] key);
        queue_status_t st;
        st.err = 1'b0;
        case (op)
            OP_PUSH: begin
                if (stored_keys.size() >= CAPACITY) st.err = 1'b1;
                else stored_keys.insert(stored_keys.size(), key);
            end
            OP_POP: begin
                if (stored_keys.size() == 0) st.err = 1'b1;
                else stored_keys.delete(largest_index());
            end
            OP_CLEAR: stored_keys.delete();
            default: ;
        endcase
        if (stored_keys.size() == 0) begin
            st.top   = '0;
            st.empty = 1'b1;
        end else begin
            st.top   = stored_keys[largest_index()];
            st.empty = 1'b0;
        end
        st.cnt = COUNT_OUT_W'(stored_keys.size());
        expected_status.insert(expected_status.size(), st);
    endtask

    // Request driver: holds the front of pending_reqs until it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_status(op_t'(s_operation), s_value);
                void'(pending_reqs.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid     <= 1'b1;
                    s_operation <= pending_reqs[0].op;
                    s_value     <= pending_reqs[0].value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    if (m_top_value !== expected_status[0].top)
                        report_mismatch($sformatf("top_value got %0d want %0d",
                                        m_top_value, expected_status[0].top));
                    if (m_count !== expected_status[0].cnt)
                        report_mismatch($sformatf("count got %0d want %0d",
                                        m_count, expected_status[0].cnt));
                    if (m_is_empty !== expected_status[0].empty)
                        report_mismatch($sformatf("is_empty got %b want %b",
                                        m_is_empty, expected_status[0].empty));
                    if (m_error !== expected_status[0].err)
                        report_mismatch($sformatf("error got %b want %b",
                                        m_error, expected_status[0].err));
                    void'(expected_status.pop_front());
                end
            end
            m_ready <= !hold_active && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off so the queue backs up into the input
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    task automatic add_req(input op_t op, input logic signed [KEY_W-1:0] key);
        mpq_req_t r;
        r.op    = op;
        r.value = key;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Mostly full-range keys, with extremes and a narrow band for duplicates
    function automatic logic signed [KEY_W-1:0] rand_key();
        int unsigned pick;
        pick = $urandom_range(7);
        case (pick)
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t rand_op();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) return OP_PUSH;
        else if (pick < 80) return OP_POP;
        else if (pick < 85) return OP_CLEAR;
        else return OP_QUERY;
    endfunction

    // Push and pop bursts drive the count across its whole range, incl. full and empty
    task automatic add_random_reqs(input int n);
        int left;
        int burst;
        int unsigned kind;
        left = n;
        while (left > 0) begin
            kind  = $urandom_range(9);
            burst = $urandom_range(20, 1);
            if (kind == 9) burst = 1;
            if (burst > left) burst = left;
            for (int i = 0; i < burst; i++) begin
                if (kind <= 3) add_req(OP_PUSH, rand_key());
                else if (kind <= 6) add_req(OP_POP, rand_key());
                else if (kind <= 8) add_req(rand_op(), rand_key());
                else add_req($urandom_range(1) ? OP_CLEAR : OP_QUERY, rand_key());
            end
            left -= burst;
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_status.size() != 0) @(posedge aclk);
    endtask

    // Main sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty-queue cases, extremes, fill to full, overflow, clear
        add_req(OP_QUERY, KEY_MAX);
        add_req(OP_POP,   '0);
        add_req(OP_CLEAR, '0);
        add_req(OP_PUSH,  KEY_MAX);
        add_req(OP_PUSH,  KEY_MIN);
        add_req(OP_POP,   KEY_MIN);
        add_req(OP_PUSH,  -1);
        add_req(OP_PUSH,  '0);
        add_req(OP_PUSH,  KEY_MIN);
        add_req(OP_PUSH,  KEY_MAX);
        add_req(OP_PUSH,  32'sh55555555);
        add_req(OP_PUSH,  32'shaaaaaaaa);
        add_req(OP_PUSH,  KEY_MAX);
        add_req(OP_PUSH,  7);
        add_req(OP_PUSH,  7);
        add_req(OP_PUSH,  -7);
        add_req(OP_PUSH,  1);
        add_req(OP_PUSH,  -2);
        add_req(OP_PUSH,  100);
        add_req(OP_PUSH,  -100);
        add_req(OP_PUSH,  3);
        add_req(OP_PUSH,  12345);
        add_req(OP_QUERY, '0);
        add_req(OP_CLEAR, KEY_MAX);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge aclk);
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
                default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
            endcase
            if (phase == 1) begin
                // sender pauses mid-phase until every result is back
                add_random_reqs(PHASE_REQS / 2);
                wait_drained();
                @(negedge aclk);
                add_random_reqs(PHASE_REQS - PHASE_REQS / 2);
            end else begin
                add_random_reqs(PHASE_REQS);
                if (phase == 0) hold_go = 1'b1;
            end
            wait_drained();
        end

        repeat (4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

/* max_priority_queue_top.f */
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/max_priority_queue_top.sv
dv/tb.sv
